[hdl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and lookup tables for the UTF-8 to UTF-16
// transcoder: byte classes, the decoder transition table and the job record
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Default width of the per-string code unit counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Depth of the job queue between front and back end (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_COUNT_ONLY = 1'b0;   // register index bit paddr[2]

    // Decoder automaton
    localparam int NUM_STATES  = 9;
    localparam int NUM_CLASSES = 12;
    localparam logic [3:0] ST_ACCEPT = 4'd0;
    localparam logic [3:0] ST_REJECT = 4'd1;

    // Surrogate construction
    localparam logic [15:0] HI_SURR_BASE = 16'hD7C0;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Transition table indexed by [state][byte class]
    localparam logic [3:0] NEXT_TABLE [NUM_STATES][NUM_CLASSES] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    // Number of UTF-16 words a job carries
    typedef enum logic [1:0] {
        WORDS_NONE = 2'd0,
        WORDS_ONE  = 2'd1,
        WORDS_TWO  = 2'd2
    } word_num_t;

    // One queued job: the results caused by one input byte
    typedef struct packed {
        logic [15:0] word0;    // single word, or high surrogate
        logic [15:0] word1;    // low surrogate
        word_num_t   nwords;
        logic        last;     // byte closed the string
        logic        failed;   // string ended outside the accept state
    } job_t;

    // Map a byte to its class
    function automatic logic [3:0] byte_class(input logic [7:0] b);
        logic [3:0] cls;
        priority if (b < 8'h80) cls = 4'd0;
        else if (b < 8'h90)     cls = 4'd1;
        else if (b < 8'hA0)     cls = 4'd9;
        else if (b < 8'hC0)     cls = 4'd7;
        else if (b < 8'hC2)     cls = 4'd8;
        else if (b < 8'hE0)     cls = 4'd2;
        else if (b == 8'hE0)    cls = 4'd10;
        else if (b == 8'hED)    cls = 4'd4;
        else if (b < 8'hF0)     cls = 4'd3;
        else if (b == 8'hF0)    cls = 4'd11;
        else if (b < 8'hF4)     cls = 4'd6;
        else if (b == 8'hF4)    cls = 4'd5;
        else                    cls = 4'd8;
        return cls;
    endfunction

endpackage

[hdl/u8u16_front.sv]
// ----------------------------------------------------------------------------
// u8u16_front
// Front end: accepts one UTF-8 byte per beat, steps the validating decoder,
// builds the UTF-16 words and the string count, and pushes a job per byte
// that has results.
// ----------------------------------------------------------------------------
module u8u16_front #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   count_only,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,     // [7:0] in_byte
    input  logic                   s_tlast,     // end_of_string
    input  logic                   queue_full,
    output logic                   push,
    output u8u16_pkg::job_t        push_job,
    output logic [COUNT_WIDTH-1:0] push_count
);
    import u8u16_pkg::*;

    logic [3:0]             state_reg;
    logic [20:0]            acc_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;

    logic                   accept;
    logic [3:0]             st_eff;
    logic [3:0]             cls;
    logic [3:0]             st_new;
    logic [20:0]            acc_new;
    logic                   cp_done;
    logic                   cp_wide;
    logic [7:0]             lead_mask;
    logic [15:0]            hi_word;
    logic [15:0]            lo_word;
    logic [1:0]             cnt_inc;
    logic [COUNT_WIDTH:0]   cnt_sum;
    logic [COUNT_WIDTH-1:0] cnt_sat;
    word_num_t              nwords;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Step the decoder: classify, gather payload bits, look up next state
    always_comb
    begin
        st_eff    = (state_reg >= 4'(NUM_STATES)) ? ST_REJECT : state_reg;
        cls       = byte_class(s_tdata);
        lead_mask = 8'hFF >> cls;
        if (st_eff != ST_ACCEPT)
        begin
            acc_new = {acc_reg[14:0], s_tdata[5:0]};
        end
        else
        begin
            acc_new = {13'd0, lead_mask & s_tdata};
        end
        st_new  = NEXT_TABLE[st_eff][cls];
        cp_done = (st_new == ST_ACCEPT);
        cp_wide = |acc_new[20:16];
        hi_word = HI_SURR_BASE + {5'd0, acc_new[20:10]};
        lo_word = LO_SURR_BASE + {6'd0, acc_new[9:0]};
    end

    // Count code units, saturating at all ones
    always_comb
    begin
        cnt_inc = !cp_done ? 2'd0 : (cp_wide ? 2'd2 : 2'd1);
        cnt_sum = {1'b0, cnt_reg} + {{(COUNT_WIDTH-1){1'b0}}, cnt_inc};
        cnt_sat = cnt_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : cnt_sum[COUNT_WIDTH-1:0];
    end

    // Build the job for this byte
    always_comb
    begin
        if (cp_done && !count_only)
        begin
            nwords = cp_wide ? WORDS_TWO : WORDS_ONE;
        end
        else
        begin
            nwords = WORDS_NONE;
        end
        push_job.nwords = nwords;
        push_job.word1  = lo_word;
        unique case (nwords)
            WORDS_ONE: push_job.word0 = acc_new[15:0];
            WORDS_TWO: push_job.word0 = hi_word;
            default:   push_job.word0 = 16'd0;
        endcase
        push_job.last   = s_tlast;
        push_job.failed = s_tlast && (st_new != ST_ACCEPT);
        push_count      = s_tlast ? cnt_sat : '0;
        push            = accept && ((nwords != WORDS_NONE) || s_tlast);
    end

    // Hold decoder state; reset it at the end of each string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                state_reg <= ST_ACCEPT;
                acc_reg   <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                state_reg <= st_new;
                acc_reg   <= acc_new;
                cnt_reg   <= cnt_sat;
            end
        end
    end

endmodule

[hdl/u8u16_queue.sv]
// ----------------------------------------------------------------------------
// u8u16_queue
// Short first-in first-out queue of jobs between front and back end, with the
// head shown combinationally.
// ----------------------------------------------------------------------------
module u8u16_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign empty     = (fill_reg == '0);
    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = slot_reg[rd_ptr_reg];

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/u8u16_back.sv]
// ----------------------------------------------------------------------------
// u8u16_back
// Back end: unpacks each queued job into one or two result beats and holds
// them in the output register until the sink takes them.
// ----------------------------------------------------------------------------
module u8u16_back #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF,
    parameter int TDATA_W     = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  u8u16_pkg::job_t        head_job,
    input  logic [COUNT_WIDTH-1:0] head_count,
    input  logic                   head_empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // [15:0] utf16_word, [16] decode_failed,
                                              // [16+COUNT_WIDTH:17] word_count, rest 0
    output logic                   m_tuser,   // [0] word_valid
    output logic                   m_tlast    // string_done
);
    import u8u16_pkg::*;

    localparam int PAD_W = TDATA_W - 17 - COUNT_WIDTH;

    logic                   out_valid_reg;
    logic [15:0]            word_reg;
    logic                   wvalid_reg;
    logic                   done_reg;
    logic                   failed_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   phase_reg;   // high surrogate of a pair already loaded

    logic                   load;
    logic                   first_of_pair;

    assign load          = !head_empty && (!out_valid_reg || m_tready);
    assign first_of_pair = (head_job.nwords == WORDS_TWO) && !phase_reg;
    assign pop           = load && !first_of_pair;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, count_reg, failed_reg, word_reg};
    assign m_tuser  = wvalid_reg;
    assign m_tlast  = done_reg;

    // Load the next beat of the head job
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (first_of_pair)
            begin
                word_reg   <= head_job.word0;
                wvalid_reg <= 1'b1;
                done_reg   <= 1'b0;
                failed_reg <= 1'b0;
                count_reg  <= '0;
            end
            else
            begin
                word_reg   <= (head_job.nwords == WORDS_TWO) ? head_job.word1
                                                             : head_job.word0;
                wvalid_reg <= (head_job.nwords != WORDS_NONE);
                done_reg   <= head_job.last;
                failed_reg <= head_job.failed;
                count_reg  <= head_count;
            end
        end
    end

    // Track output valid and pair phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= first_of_pair;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hdl/utf8_to_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Validating UTF-8 to UTF-16 transcoder with per-string status and count.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle on the slave stream while the queue is
// not full; the front end steps the decoder automaton and the code unit counter in
// that same cycle, so input is never held up by decoding. Each byte that yields
// results becomes one job in a four-entry queue; the back end sends one result beat
// per cycle from its output register while the sink is ready, so a code point above
// 0xFFFF (a surrogate pair) takes two output beats. Sustained rate is one byte per
// cycle as long as the output side averages no more than one beat per byte; the
// output port, one beat per cycle, sets the limit. A byte's first result is registered
// in the queue and then in the output register. The last byte of a string (tlast)
// gives the closing beat with tlast, decode status and the saturating word count, and
// resets the decoder. Register count_only at address 0 suppresses the word beats.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [u8u16_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [u8u16_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [u8u16_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    // byte input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] in_byte
    input  logic                                s_tlast,   // end_of_string
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((17+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,   // [15:0] utf16_word,
                                                           // [16] decode_failed,
                                                           // then word_count, pad 0
    output logic                                m_tuser,   // [0] word_valid
    output logic                                m_tlast    // string_done
);
    import u8u16_pkg::*;

    localparam int TDATA_W = ((17 + COUNT_WIDTH + 7) / 8) * 8;
    localparam int JOB_W   = $bits(job_t);
    localparam int ENTRY_W = JOB_W + COUNT_WIDTH;

    logic                   count_only_reg;
    logic                   cfg_sel;
    logic                   push;
    job_t                   push_job;
    logic [COUNT_WIDTH-1:0] push_count;
    logic [ENTRY_W-1:0]     head_entry;
    job_t                   head_job;
    logic [COUNT_WIDTH-1:0] head_count;
    logic                   pop;
    logic                   queue_empty;
    logic                   queue_full;

    // Decode the register file
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == REG_COUNT_ONLY);
    assign prdata  = cfg_sel ? {{(CFG_DATA_W-1){1'b0}}, count_only_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_only_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            count_only_reg <= pwdata[0];
        end
    end

    u8u16_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .count_only (count_only_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job),
        .push_count (push_count)
    );

    u8u16_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_count, push_job}),
        .pop       (pop),
        .head_data (head_entry),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Split the queue head into job record and count
    assign head_job   = job_t'(head_entry[JOB_W-1:0]);
    assign head_count = head_entry[ENTRY_W-1:JOB_W];

    u8u16_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TDATA_W     (TDATA_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_count (head_count),
        .head_empty (queue_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
